// File: hdl/cpd_pkg.sv
// Shared types and constants of the command packet decoder.
package cpd_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_LEN    = 3'd1,
    ST_BAD_HDR    = 3'd2,
    ST_BAD_CRC    = 3'd3,
    ST_BAD_FIELDS = 3'd4
  } status_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ARM      = 2'd0,
    REG_VELOCITY = 2'd1,
    REG_STOP     = 2'd2
  } reg_index_t;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  // Opcode numbers after reset.
  localparam logic [7:0] ARM_CODE_RESET      = 8'd1;
  localparam logic [7:0] VELOCITY_CODE_RESET = 8'd2;
  localparam logic [7:0] STOP_CODE_RESET     = 8'd3;

  // Packet layout.
  localparam logic [5:0] POS_HDR0     = 6'd0;
  localparam logic [5:0] POS_HDR1     = 6'd1;
  localparam logic [5:0] POS_HDR2     = 6'd2;
  localparam logic [5:0] POS_OPCODE   = 6'd3;
  localparam logic [5:0] POS_LAST     = 6'd35;
  localparam logic [5:0] CRC_SPAN     = 6'd32;
  localparam logic [5:0] COUNT_MAX    = 6'd37;
  localparam logic [7:0] HDR_BYTE0    = 8'h41;
  localparam logic [7:0] HDR_BYTE1    = 8'h4D;
  localparam logic [7:0] HDR_BYTE2    = 8'h01;

  // CRC32C, reflected form.
  localparam logic [31:0] CRC_POLY = 32'h82F63B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Velocity word limits, read as signed 32-bit.
  localparam logic [31:0] VEL_MAX_WORD = 32'h00007FFF;
  localparam logic [31:0] VEL_MIN_WORD = 32'hFFFF8001;

  // Opcode numbers as configured.
  typedef struct packed {
    logic [7:0] arm_code;
    logic [7:0] velocity_code;
    logic [7:0] stop_code;
  } cfg_t;

  // One assembled packet, handed from the front to the back.
  typedef struct packed {
    status_t          status;
    logic [7:0]       opcode;
    logic [31:0]      session;
    logic [31:0]      sequence_num;
    logic [31:0]      deadline;
    logic [3:0][31:0] vel_word;
  } rec_t;

  // One result beat, laid out as it leaves on m_tdata (status lowest).
  typedef struct packed {
    logic [4:0]         pad;
    logic signed [15:0] velocity_d;
    logic signed [15:0] velocity_c;
    logic signed [15:0] velocity_b;
    logic signed [15:0] velocity_a;
    logic [31:0]        valid_until;
    logic [31:0]        sequence_res;
    logic [31:0]        session;
    logic [7:0]         opcode;
    status_t            status;
  } result_t;

endpackage

// File: hdl/cpd_front.sv
// Front end: counts packet bytes, runs the CRC, checks the header and gathers fields.
module cpd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [7:0]     byte_in,
  input  logic           last,
  output logic           rec_push,
  output cpd_pkg::rec_t  rec
);

  logic [5:0]       byte_count;
  logic [31:0]      crc_running;
  logic             header_good;
  logic [7:0]       opcode_hold;
  logic [31:0]      session_hold;
  logic [31:0]      sequence_hold;
  logic [31:0]      deadline_hold;
  logic [3:0][31:0] vel_word;
  logic [31:0]      received_crc;
  logic [31:0]      crc_next;
  logic             header_bad;

  // One byte of the reflected CRC32C, unrolled over its eight bits.
  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ cpd_pkg::CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  assign crc_next = crc_step(crc_running, byte_in);

  assign header_bad = ((byte_count == cpd_pkg::POS_HDR0) && (byte_in != cpd_pkg::HDR_BYTE0)) ||
                      ((byte_count == cpd_pkg::POS_HDR1) && (byte_in != cpd_pkg::HDR_BYTE1)) ||
                      ((byte_count == cpd_pkg::POS_HDR2) && (byte_in != cpd_pkg::HDR_BYTE2));

  // Packet position, CRC and header flag; the final beat starts a new packet.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      crc_running <= cpd_pkg::CRC_INIT;
      header_good <= 1'b1;
    end else if (take) begin
      if (last) begin
        byte_count  <= '0;
        crc_running <= cpd_pkg::CRC_INIT;
        header_good <= 1'b1;
      end else begin
        if (byte_count != cpd_pkg::COUNT_MAX) begin
          byte_count <= byte_count + 6'd1;
        end
        if (byte_count < cpd_pkg::CRC_SPAN) begin
          crc_running <= crc_next;
        end
        if (header_bad) begin
          header_good <= 1'b0;
        end
      end
    end
  end

  // Field bytes land in their little-endian lanes; bytes past the end are dropped.
  always_ff @(posedge clk) begin
    if (take) begin
      if (byte_count == cpd_pkg::POS_OPCODE) begin
        opcode_hold <= byte_in;
      end else if (byte_count[5:2] == 4'd1) begin
        session_hold[8*byte_count[1:0] +: 8] <= byte_in;
      end else if (byte_count[5:2] == 4'd2) begin
        sequence_hold[8*byte_count[1:0] +: 8] <= byte_in;
      end else if (byte_count[5:2] == 4'd3) begin
        deadline_hold[8*byte_count[1:0] +: 8] <= byte_in;
      end else if (byte_count[5:4] == 2'd1) begin
        vel_word[byte_count[3:2]][8*byte_count[1:0] +: 8] <= byte_in;
      end else if (byte_count[5:2] == 4'd8) begin
        received_crc[8*byte_count[1:0] +: 8] <= byte_in;
      end
    end
  end

  // The packet record goes out with the final beat, whose byte is the top CRC lane.
  always_comb begin
    rec_push         = take && last;
    rec.opcode       = opcode_hold;
    rec.session      = session_hold;
    rec.sequence_num = sequence_hold;
    rec.deadline     = deadline_hold;
    rec.vel_word     = vel_word;
    if (byte_count != cpd_pkg::POS_LAST) begin
      rec.status = cpd_pkg::ST_BAD_LEN;
    end else if (!header_good) begin
      rec.status = cpd_pkg::ST_BAD_HDR;
    end else if ({byte_in, received_crc[23:0]} != ~crc_running) begin
      rec.status = cpd_pkg::ST_BAD_CRC;
    end else begin
      rec.status = cpd_pkg::ST_OK;
    end
  end

endmodule

// File: hdl/cpd_queue.sv
// Short FIFO of packet records between the front and the back.
module cpd_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hdl/cpd_back.sv
// Back end: validates the decoded fields and holds the result beat for the receiver.
module cpd_back (
  input  logic              clk,
  input  logic              rst,
  input  cpd_pkg::cfg_t     cfg,
  input  logic              rec_valid,
  input  cpd_pkg::rec_t     rec,
  output logic              rec_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output cpd_pkg::result_t  res
);

  logic              fields_ok;
  logic [3:0]        vel_ok;
  cpd_pkg::status_t  status;
  cpd_pkg::result_t  res_next;

  // Per-word velocity checks: in range, and zero unless this is a velocity command.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vel_ok[i] = ((rec.vel_word[i] <= cpd_pkg::VEL_MAX_WORD) ||
                   (rec.vel_word[i] >= cpd_pkg::VEL_MIN_WORD)) &&
                  ((rec.opcode == cfg.velocity_code) || (rec.vel_word[i] == '0));
    end
  end

  assign fields_ok = (rec.session != '0) &&
                     (rec.opcode >= cfg.arm_code) && (rec.opcode <= cfg.stop_code) &&
                     !((rec.opcode == cfg.arm_code) && (rec.sequence_num != '0)) &&
                     (&vel_ok);

  // Final status; a failed packet carries zeros in every other field.
  always_comb begin
    if (rec.status != cpd_pkg::ST_OK) begin
      status = rec.status;
    end else if (!fields_ok) begin
      status = cpd_pkg::ST_BAD_FIELDS;
    end else begin
      status = cpd_pkg::ST_OK;
    end
    res_next = '0;
    res_next.status = status;
    if (status == cpd_pkg::ST_OK) begin
      res_next.opcode       = rec.opcode;
      res_next.session      = rec.session;
      res_next.sequence_res = rec.sequence_num;
      res_next.valid_until  = rec.deadline;
      res_next.velocity_a   = $signed(rec.vel_word[0][15:0]);
      res_next.velocity_b   = $signed(rec.vel_word[1][15:0]);
      res_next.velocity_c   = $signed(rec.vel_word[2][15:0]);
      res_next.velocity_d   = $signed(rec.vel_word[3][15:0]);
    end
  end

  // Output register loads whenever it is empty or its beat is being taken.
  assign rec_pop = rec_valid && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      res_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      res <= res_next;
    end
  end

endmodule

// File: hdl/command_packet_decoder_core.sv
// Command packet decoder: byte stream in, one decoded result beat per packet out.
//
// The slave channel (s_tvalid, s_tready, s_tdata, s_tlast) takes one packet byte per
// beat, s_tlast marking the final byte. Each beat with s_tlast yields exactly one
// beat on the master channel (m_tvalid, m_tready, m_tdata) carrying a status and the
// decoded fields; a packet is good only at 36 bytes with the 'A','M',1 header, a
// matching CRC32C over bytes 0..31 and valid fields. Non-ok results carry zeros.
// Throughput is one byte per cycle while s_tready is high; the CRC of a byte is
// computed in that cycle. The edge that takes the final byte writes the record queue;
// the validated result is loaded into the output register once the record heads the
// queue and that register is empty or its beat is being taken.
// The queue between the byte front end and the validator holds QUEUE_DEPTH packets,
// so when m_tready is low the input keeps flowing until that many results wait
// behind the output register; s_tready then drops until the receiver takes a beat.
// The opcode numbers are to be written via cfg_we/cfg_index/cfg_data while idle; the
// block does not enforce it. Reset clears the byte position, CRC, header flag, queue
// and output valid, and returns the opcode numbers to arm 1, velocity 2, stop 3.
module command_packet_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // byte_in
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status[2:0], opcode[10:3], session[42:11], sequence_res[74:43],
  // valid_until[106:75], velocity_a..velocity_d[170:107], zeros[175:171]
  output logic [175:0]                   m_tdata,
  input  logic                           cfg_we,
  input  logic [cpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cpd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned REC_W = $bits(cpd_pkg::rec_t);

  cpd_pkg::cfg_t     cfg;
  cpd_pkg::rec_t     front_rec;
  cpd_pkg::rec_t     back_rec;
  cpd_pkg::result_t  res;
  logic              take;
  logic              q_push;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic [REC_W-1:0]  q_out;

  // Opcode number registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm_code      <= cpd_pkg::ARM_CODE_RESET;
      cfg.velocity_code <= cpd_pkg::VELOCITY_CODE_RESET;
      cfg.stop_code     <= cpd_pkg::STOP_CODE_RESET;
    end else if (cfg_we) begin
      unique case (cpd_pkg::reg_index_t'(cfg_index))
        cpd_pkg::REG_ARM:      cfg.arm_code      <= cfg_data;
        cpd_pkg::REG_VELOCITY: cfg.velocity_code <= cfg_data;
        cpd_pkg::REG_STOP:     cfg.stop_code     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input beats are taken while the record queue has room.
  assign s_tready = !q_full;
  assign take     = s_tvalid && s_tready;

  cpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .byte_in  (s_tdata),
    .last     (s_tlast),
    .rec_push (q_push),
    .rec      (front_rec)
  );

  cpd_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_rec),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  assign back_rec = cpd_pkg::rec_t'(q_out);

  cpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec_valid (!q_empty),
    .rec       (back_rec),
    .rec_pop   (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = res;

`ifndef SYNTHESIS
  // A record is never offered to a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) q_full |-> !q_push)
    else $error("packet record pushed into a full queue");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= cpd_pkg::ST_BAD_FIELDS))
    else $error("result status out of range");

  // A failed packet carries zeros in every other field.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[2:0] != cpd_pkg::ST_OK)) |-> (m_tdata[175:3] == '0))
    else $error("failed packet carries nonzero fields");

  // No result appears in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");
`endif

endmodule
